### rtl/lsm_pkg.sv
// shared types, constants and state encoding for the sieve table core
`default_nettype none

package lsm_pkg;

    // field widths fixed by the interface
    localparam int IDX_W    = 13;
    localparam int MU_W     = 2;
    localparam int OM_W     = 3;
    localparam int TOTAL_W  = 11;
    localparam int PROD_W   = 2 * IDX_W;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int MAX_INDEX_DEF   = 4096;
    localparam int PRIME_SLOTS_DEF = 1024;

    localparam logic [IDX_W-1:0]   LIMIT_RST = 13'd4096;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // register index decoded from paddr[2]
    localparam logic REG_SIEVE_LIMIT = 1'b0;

    // command codes
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // moebius values
    localparam logic signed [MU_W-1:0] MU_ZERO = 2'sb00;
    localparam logic signed [MU_W-1:0] MU_POS  = 2'sb01;
    localparam logic signed [MU_W-1:0] MU_NEG  = 2'sb11;

    typedef struct packed {
        logic [IDX_W-1:0]          lf;
        logic signed [MU_W-1:0]    mu;
        logic [OM_W-1:0]           om;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic [IDX_W-1:0] eff_limit;
        logic             wr;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QREAD,
        S_QRESP,
        S_CLEAR,
        S_IREAD,
        S_ITEST,
        S_KREAD,
        S_KMUL,
        S_KCHK,
        S_NEXT,
        S_BRESP
    } state_t;

endpackage

`default_nettype wire

### rtl/lsm_ram.sv
// generic single write port ram with registered read
`default_nettype none

module lsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/lsm_cfg.sv
// apb register file holding the sieve limit
`default_nettype none

module lsm_cfg
    import lsm_pkg::*;
#(
    parameter int MAX_INDEX = MAX_INDEX_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    logic [IDX_W-1:0] limit_reg;
    logic             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_SIEVE_LIMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RST;
        end else if (wr_hit) begin
            limit_reg <= pwdata[IDX_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_SIEVE_LIMIT) begin
            prdata = PDATA_W'(limit_reg);
        end
    end

    // limit above the table size saturates
    assign cfg.eff_limit = (32'(limit_reg) > 32'(MAX_INDEX)) ? IDX_W'(MAX_INDEX) : limit_reg;
    assign cfg.wr        = wr_hit;

endmodule

`default_nettype wire

### rtl/lsm_ctrl.sv
// sequencer with shared multiplier: clear pass, linear sieve walk, queries
`default_nettype none

module lsm_ctrl
    import lsm_pkg::*;
#(
    parameter int MAX_INDEX   = MAX_INDEX_DEF,
    parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire cfg_t                      cfg,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic                      s_cmd,
    input  wire logic [IDX_W-1:0]          s_index,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_valid_res,
    output logic signed [MU_W-1:0]         m_mobius,
    output logic        [OM_W-1:0]         m_distinct_primes,
    output logic        [IDX_W-1:0]        m_least_prime,
    output logic        [TOTAL_W-1:0]      m_prime_total
);

    localparam int TBL_DEPTH = MAX_INDEX + 1;
    localparam int AW        = $clog2(TBL_DEPTH);
    localparam int PW        = $clog2(PRIME_SLOTS);
    localparam int CNT_W     = $clog2(PRIME_SLOTS + 1);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     pos_reg, pos_next;
    logic [IDX_W-1:0]     lim_reg, lim_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    entry_t               ent_reg, ent_next;
    logic [IDX_W-1:0]     p_reg, p_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 built_reg, built_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 res_valid_reg, res_valid_next;
    logic signed [MU_W-1:0] res_mu_reg, res_mu_next;
    logic [OM_W-1:0]      res_om_reg, res_om_next;
    logic [IDX_W-1:0]     res_lf_reg, res_lf_next;
    logic [TOTAL_W-1:0]   res_total_reg, res_total_next;

    logic                 tbl_we, tbl_re;
    logic [AW-1:0]        tbl_waddr, tbl_raddr;
    logic [ENTRY_W-1:0]   tbl_wdata, tbl_rdata;
    logic                 pl_we, pl_re;
    logic [PW-1:0]        pl_waddr, pl_raddr;
    logic [IDX_W-1:0]     pl_wdata, pl_rdata;

    entry_t               rd_ent, new_ent;
    logic                 out_free;
    logic                 q_ok;
    logic                 same_prime;
    logic [TOTAL_W-1:0]   total;

    lsm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    lsm_ram #(
        .WIDTH (IDX_W),
        .DEPTH (PRIME_SLOTS)
    ) u_primes (
        .aclk  (aclk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .re    (pl_re),
        .raddr (pl_raddr),
        .rdata (pl_rdata)
    );

    assign rd_ent     = entry_t'(tbl_rdata);
    assign out_free   = !m_valid_reg || m_ready;
    assign q_ok       = built_reg && (idx_reg <= cfg.eff_limit);
    assign same_prime = (ent_reg.lf == p_reg);
    assign total      = (32'(cnt_reg) > 32'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(cnt_reg);

    assign s_ready           = (state_reg == S_IDLE);
    assign m_valid           = m_valid_reg;
    assign m_valid_res       = res_valid_reg;
    assign m_mobius          = res_mu_reg;
    assign m_distinct_primes = res_om_reg;
    assign m_least_prime     = res_lf_reg;
    assign m_prime_total     = res_total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            built_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            built_reg   <= built_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg       <= pos_next;
        lim_reg       <= lim_next;
        idx_reg       <= idx_next;
        k_reg         <= k_next;
        ent_reg       <= ent_next;
        p_reg         <= p_next;
        prod_reg      <= prod_next;
        res_valid_reg <= res_valid_next;
        res_mu_reg    <= res_mu_next;
        res_om_reg    <= res_om_next;
        res_lf_reg    <= res_lf_next;
        res_total_reg <= res_total_next;
    end

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        ent_next       = ent_reg;
        p_next         = p_reg;
        prod_next      = prod_reg;
        built_next     = built_reg && !cfg.wr;
        m_valid_next   = m_valid_reg && !m_ready;
        res_valid_next = res_valid_reg;
        res_mu_next    = res_mu_reg;
        res_om_next    = res_om_reg;
        res_lf_next    = res_lf_reg;
        res_total_next = res_total_reg;

        tbl_we    = 1'b0;
        tbl_waddr = AW'(pos_reg);
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = AW'(pos_reg);
        pl_we     = 1'b0;
        pl_waddr  = PW'(cnt_reg);
        pl_wdata  = pos_reg;
        pl_re     = 1'b0;
        pl_raddr  = PW'(k_reg);
        new_ent   = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == CMD_QUERY) begin
                        idx_next   = s_index;
                        state_next = S_QREAD;
                    end else begin
                        lim_next   = cfg.eff_limit;
                        pos_next   = '0;
                        cnt_next   = '0;
                        state_next = S_CLEAR;
                    end
                end
            end
            S_QREAD: begin
                tbl_re     = 1'b1;
                tbl_raddr  = AW'(idx_reg);
                state_next = S_QRESP;
            end
            S_QRESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    res_valid_next = q_ok;
                    res_mu_next    = q_ok ? rd_ent.mu : MU_ZERO;
                    res_om_next    = q_ok ? rd_ent.om : '0;
                    res_lf_next    = q_ok ? rd_ent.lf : '0;
                    res_total_next = total;
                    state_next     = S_IDLE;
                end
            end
            S_CLEAR: begin
                // index one starts with moebius one, all else zero
                new_ent.mu = (pos_reg == IDX_W'(1)) ? MU_POS : MU_ZERO;
                tbl_we     = 1'b1;
                tbl_wdata  = new_ent;
                if (pos_reg == lim_reg) begin
                    if (lim_reg < IDX_W'(2)) begin
                        state_next = S_BRESP;
                    end else begin
                        pos_next   = IDX_W'(2);
                        state_next = S_IREAD;
                    end
                end else begin
                    pos_next = pos_reg + IDX_W'(1);
                end
            end
            S_IREAD: begin
                tbl_re     = 1'b1;
                state_next = S_ITEST;
            end
            S_ITEST: begin
                k_next     = '0;
                state_next = S_KREAD;
                if (rd_ent.lf == '0) begin
                    // not struck by any smaller prime: a new prime
                    new_ent.lf = pos_reg;
                    new_ent.mu = MU_NEG;
                    new_ent.om = OM_W'(1);
                    tbl_we     = 1'b1;
                    tbl_wdata  = new_ent;
                    ent_next   = new_ent;
                    if (32'(cnt_reg) < 32'(PRIME_SLOTS)) begin
                        pl_we    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end else begin
                    ent_next = rd_ent;
                end
            end
            S_KREAD: begin
                if (k_reg < cnt_reg) begin
                    pl_re      = 1'b1;
                    state_next = S_KMUL;
                end else begin
                    state_next = S_NEXT;
                end
            end
            S_KMUL: begin
                p_next     = pl_rdata;
                prod_next  = PROD_W'(pos_reg) * PROD_W'(pl_rdata);
                state_next = S_KCHK;
            end
            S_KCHK: begin
                if (prod_reg > PROD_W'(lim_reg)) begin
                    state_next = S_NEXT;
                end else begin
                    new_ent.lf = p_reg;
                    new_ent.mu = same_prime ? MU_ZERO : -ent_reg.mu;
                    new_ent.om = same_prime ? ent_reg.om : ent_reg.om + OM_W'(1);
                    tbl_we     = 1'b1;
                    tbl_waddr  = AW'(prod_reg);
                    tbl_wdata  = new_ent;
                    if (same_prime) begin
                        state_next = S_NEXT;
                    end else begin
                        k_next     = k_reg + CNT_W'(1);
                        state_next = S_KREAD;
                    end
                end
            end
            S_NEXT: begin
                if (pos_reg == lim_reg) begin
                    state_next = S_BRESP;
                end else begin
                    pos_next   = pos_reg + IDX_W'(1);
                    state_next = S_IREAD;
                end
            end
            S_BRESP: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    res_valid_next = 1'b1;
                    res_mu_next    = MU_ZERO;
                    res_om_next    = '0;
                    res_lf_next    = '0;
                    res_total_next = total;
                    built_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/linear_sieve_mobius_table_core.sv
// Linear sieve table core: least prime, moebius and distinct prime count per index.
// A query reads the table in S_QREAD and registers its result in S_QRESP, then returns to S_IDLE.
// A build clears indices 0..limit, then walks every index from 2 through S_IREAD, S_ITEST, S_NEXT,
// with a multiplier probe (S_KREAD, S_KMUL, S_KCHK) per strike and for the last probe past the limit.
// The input is not ready while an item is at work; a result may wait in the output register.
// Synchronous active-low reset: idle, limit 4096, prime count 0, tables not built.
`default_nettype none

module linear_sieve_mobius_table_core
    import lsm_pkg::*;
#(
    parameter int MAX_INDEX   = MAX_INDEX_DEF,
    parameter int PRIME_SLOTS = PRIME_SLOTS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [PADDR_W-1:0]    paddr,
    input  wire logic [PDATA_W-1:0]    pwdata,
    output logic      [PDATA_W-1:0]    prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_cmd,
    input  wire logic [IDX_W-1:0]      s_index,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_valid_res,
    output logic signed [MU_W-1:0]     m_mobius,
    output logic        [OM_W-1:0]     m_distinct_primes,
    output logic        [IDX_W-1:0]    m_least_prime,
    output logic        [TOTAL_W-1:0]  m_prime_total
);

    cfg_t cfg;

    lsm_cfg #(
        .MAX_INDEX (MAX_INDEX)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lsm_ctrl #(
        .MAX_INDEX   (MAX_INDEX),
        .PRIME_SLOTS (PRIME_SLOTS)
    ) u_ctrl (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_mobius          (m_mobius),
        .m_distinct_primes (m_distinct_primes),
        .m_least_prime     (m_least_prime),
        .m_prime_total     (m_prime_total)
    );

endmodule

`default_nettype wire

### rtl/lsm_checker.sv
// port-level checker for the sieve table core, bound to the top level
`default_nettype none

module lsm_checker
    import lsm_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic                   m_valid_res,
    input wire logic signed [MU_W-1:0] m_mobius,
    input wire logic [OM_W-1:0]        m_distinct_primes,
    input wire logic [IDX_W-1:0]       m_least_prime
);

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready the cycle after an accept");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped before it was taken");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_valid_res) |->
            (m_mobius == MU_ZERO && m_distinct_primes == '0 && m_least_prime == '0))
        else $error("invalid result carries table data");

    // only indices 0 and 1 have no least prime and no prime factors
    a_lf_omega_agree: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_least_prime == '0) == (m_distinct_primes == '0)))
        else $error("least prime and distinct count disagree");

endmodule

bind linear_sieve_mobius_table_core lsm_checker u_lsm_checker (.*);

`default_nettype wire

### sim/testbench.sv
// Testbench for linear_sieve_mobius_table_core: sieve predictor, random traffic, field checks
`timescale 1ns / 1ps

module testbench;
    import lsm_pkg::*;

    localparam int TARGET_ITEMS   = 1750;
    localparam int WATCHDOG_LIMIT = 300000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_GAP        = 12;
    localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_SIEVE_LIMIT, 2'b00};

    typedef struct packed {
        logic             cmd;
        logic [IDX_W-1:0] index;
    } sieve_request_t;

    typedef struct packed {
        logic                   valid_res;
        logic signed [MU_W-1:0] mobius;
        logic [OM_W-1:0]        distinct_primes;
        logic [IDX_W-1:0]       least_prime;
        logic [TOTAL_W-1:0]     prime_total;
    } sieve_answer_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_cmd = CMD_QUERY;
    logic [IDX_W-1:0]     s_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_valid_res;
    logic signed [MU_W-1:0] m_mobius;
    logic [OM_W-1:0]      m_distinct_primes;
    logic [IDX_W-1:0]     m_least_prime;
    logic [TOTAL_W-1:0]   m_prime_total;

    linear_sieve_mobius_table_core u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_cmd             (s_cmd),
        .s_index           (s_index),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_valid_res       (m_valid_res),
        .m_mobius          (m_mobius),
        .m_distinct_primes (m_distinct_primes),
        .m_least_prime     (m_least_prime),
        .m_prime_total     (m_prime_total)
    );

    // predictor state: shadow register and sieve tables
    logic [IDX_W-1:0]       cfg_limit = LIMIT_RST;
    bit                     tables_ready = 1'b0;
    int                     prime_cnt = 0;
    int                     prime_seen [0:PRIME_SLOTS_DEF-1];
    logic [IDX_W-1:0]       least_tab  [0:MAX_INDEX_DEF];
    logic signed [MU_W-1:0] mu_tab     [0:MAX_INDEX_DEF];
    logic [OM_W-1:0]        omega_tab  [0:MAX_INDEX_DEF];

    sieve_request_t sieve_requests[$];
    sieve_answer_t  sieve_answers_due[$];
    int             mismatches = 0;
    int             offered = 0;
    bit             send_gaps = 1'b0;
    bit             recv_gaps = 1'b0;
    int             holds_asked = 0;
    int             holds_served = 0;
    int             send_wait = 0;
    int             recv_wait = 0;
    int             idle_cycles = 0;
    sieve_request_t next_req;
    sieve_answer_t  want;

    function automatic int sieve_span();
        return (cfg_limit > MAX_INDEX_DEF) ? MAX_INDEX_DEF : int'(cfg_limit);
    endfunction

    // euler sieve: every composite is struck once, by its least prime
    function automatic void rebuild_sieve();
        int lim;
        int p;
        int d;
        lim = sieve_span();
        for (int i = 0; i <= MAX_INDEX_DEF; i++) begin
            least_tab[i] = '0;
            mu_tab[i]    = MU_ZERO;
            omega_tab[i] = '0;
        end
        prime_cnt = 0;
        if (lim >= 1) mu_tab[1] = MU_POS;
        for (int i = 2; i <= lim; i++) begin
            if (least_tab[i] == 0) begin
                if (prime_cnt < PRIME_SLOTS_DEF) begin
                    prime_seen[prime_cnt] = i;
                    prime_cnt++;
                end
                least_tab[i] = IDX_W'(i);
                mu_tab[i]    = MU_NEG;
                omega_tab[i] = 3'd1;
            end
            for (int k = 0; k < prime_cnt; k++) begin
                p = prime_seen[k];
                if (i * p > lim) break;
                d = i * p;
                least_tab[d] = IDX_W'(p);
                // repeated prime: mobius drops to zero, no new distinct factor
                if (least_tab[i] == p) begin
                    mu_tab[d]    = MU_ZERO;
                    omega_tab[d] = omega_tab[i];
                    break;
                end
                mu_tab[d]    = -mu_tab[i];
                omega_tab[d] = omega_tab[i] + 3'd1;
            end
        end
        tables_ready = 1'b1;
    endfunction

    function automatic sieve_answer_t sieve_answer(logic cmd, logic [IDX_W-1:0] idx);
        sieve_answer_t a;
        a = '0;
        if (cmd == CMD_BUILD) begin
            rebuild_sieve();
            a.valid_res = 1'b1;
        end else if (tables_ready && idx <= sieve_span()) begin
            a.valid_res       = 1'b1;
            a.mobius          = mu_tab[idx];
            a.distinct_primes = omega_tab[idx];
            a.least_prime     = least_tab[idx];
        end
        a.prime_total = (prime_cnt > 2047) ? TOTAL_MAX : TOTAL_W'(prime_cnt);
        return a;
    endfunction

    function automatic void offer(logic cmd, logic [IDX_W-1:0] idx);
        sieve_request_t r;
        r.cmd   = cmd;
        r.index = idx;
        sieve_requests = {sieve_requests, r};
        offered++;
    endfunction

    task automatic check_field(string field, integer want_v, integer got_v);
        if (got_v !== want_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
        end
    endtask

    // wait until every request is sent and every result is back
    task automatic drain();
        while (sieve_requests.size() != 0 || sieve_answers_due.size() != 0 || s_valid)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_limit(logic [IDX_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_limit    = value;
        tables_ready = 1'b0;
        @(negedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_valid && s_ready)
                sieve_answers_due = {sieve_answers_due, sieve_answer(s_cmd, s_index)};
            if (!s_valid || s_ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    s_valid <= 1'b0;
                end else if (sieve_requests.size() != 0) begin
                    next_req = sieve_requests.pop_front();
                    s_valid  <= 1'b1;
                    s_cmd    <= next_req.cmd;
                    s_index  <= next_req.index;
                    send_wait = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready   <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (sieve_answers_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result with no request outstanding", $time);
                end else begin
                    want = sieve_answers_due.pop_front();
                    check_field("valid_res", want.valid_res, m_valid_res);
                    check_field("mobius", $signed(want.mobius), $signed(m_mobius));
                    check_field("distinct_primes", want.distinct_primes, m_distinct_primes);
                    check_field("least_prime", want.least_prime, m_least_prime);
                    check_field("prime_total", want.prime_total, m_prime_total);
                end
                recv_wait = recv_gaps ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (holds_asked != holds_served) begin
                holds_served++;
                recv_wait = LONG_HOLD;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("linear_sieve_mobius_table_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int lim;
        int eff;
        int n;
        int big_left;
        int phase;
        int pick;
        int notable [12];
        logic [IDX_W-1:0] idx;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // nothing built yet: invalid with a zero count
        offer(CMD_QUERY, 13'd0);
        offer(CMD_QUERY, 13'd4096);
        // full build at the reset limit, then the notable indices
        offer(CMD_BUILD, IDX_W'($urandom_range(0, 8191)));
        notable = '{0, 1, 2, 4, 12, 30, 2310, 4093, 4095, 4096, 4097, 8191};
        foreach (notable[j])
            offer(CMD_QUERY, IDX_W'(notable[j]));
        drain();
        // a limit write invalidates the tables but keeps the count
        write_limit(13'd100);
        offer(CMD_QUERY, 13'd50);
        drain();
        write_limit(13'd0);
        offer(CMD_BUILD, 13'd0);
        offer(CMD_QUERY, 13'd0);
        offer(CMD_QUERY, 13'd1);
        drain();
        write_limit(13'd1);
        offer(CMD_BUILD, 13'h1FFF);
        offer(CMD_QUERY, 13'd1);
        offer(CMD_QUERY, 13'd2);
        drain();
        // limit above the table saturates
        write_limit(13'd8191);
        offer(CMD_BUILD, 13'd0);
        offer(CMD_QUERY, 13'd4096);
        offer(CMD_QUERY, 13'd4097);
        drain();

        big_left = 2;
        phase = 0;
        while (offered < TARGET_ITEMS) begin
            if (big_left > 0 && phase > 3 && $urandom_range(0, 7) == 0) begin
                lim = $urandom_range(2048, 8191);
                big_left--;
            end else begin
                lim = $urandom_range(0, 400);
            end
            eff = (lim > MAX_INDEX_DEF) ? MAX_INDEX_DEF : lim;
            write_limit(IDX_W'(lim));
            send_gaps = $urandom_range(0, 1);
            recv_gaps = $urandom_range(0, 1);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4))
                    offer(CMD_QUERY, IDX_W'($urandom_range(0, 8191)));
            end
            offer(CMD_BUILD, IDX_W'($urandom_range(0, 8191)));
            if (phase == 2) begin
                // receiver holds off while the sender keeps offering
                drain();
                send_gaps = 1'b0;
                holds_asked++;
            end
            n = $urandom_range(40, 160);
            for (int j = 0; j < n; j++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    offer(CMD_BUILD, IDX_W'($urandom_range(0, 8191)));
                end else if (pick < 10) begin
                    offer(CMD_QUERY, IDX_W'($urandom_range(0, 8191)));
                end else if (pick < 16) begin
                    case ($urandom_range(0, 3))
                        0: idx = IDX_W'(eff);
                        1: idx = IDX_W'(eff + 1);
                        2: idx = 13'd0;
                        default: idx = 13'd1;
                    endcase
                    offer(CMD_QUERY, idx);
                end else begin
                    offer(CMD_QUERY, IDX_W'($urandom_range(0, eff)));
                end
            end
            drain();
            phase++;
        end

        repeat (40) @(negedge aclk);
        if (mismatches == 0 && sieve_answers_due.size() == 0) begin
            $display("linear_sieve_mobius_table_core regression: pass");
        end else begin
            $display("linear_sieve_mobius_table_core regression: fail");
        end
        $finish;
    end

endmodule
